FILE: hw/rtl/ecu_pkg.sv
// ecu_pkg: Q30 fixed-point types, polynomial coefficients, curve codes and
// shared arithmetic helpers for the easing curve unit.
// Standalone; used by easing_curve_unit.
package ecu_pkg;

	// Q30 value, wide enough for 2.0 plus sign headroom
	typedef logic signed [32:0] q30_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       zero;   // position is exactly 0
		logic       one;    // position is exactly 1.0
		logic       lower;  // position below 0.5
	} ctl_t;

	localparam logic [2:0] MODE_LINEAR      = 3'd0;
	localparam logic [2:0] MODE_CUBIC_IN    = 3'd1;
	localparam logic [2:0] MODE_ELASTIC_IN  = 3'd2;
	localparam logic [2:0] MODE_SINE_OUT    = 3'd3;
	localparam logic [2:0] MODE_ELASTIC_OUT = 3'd4;
	localparam logic [2:0] MODE_CUBIC_IO    = 3'd5;
	localparam logic [2:0] MODE_ELASTIC_IO  = 3'd6;
	localparam logic [2:0] MODE_QUART_OUT   = 3'd7;

	localparam q30_t ONE  = 33'sd1073741824;
	localparam q30_t HALF = 33'sd536870912;

	// odd quarter-wave sine polynomial, highest order first
	localparam q30_t SIN_C9 = 33'sd172272;
	localparam q30_t SIN_C7 = -33'sd5026993;
	localparam q30_t SIN_C5 = 33'sd85569306;
	localparam q30_t SIN_C3 = -33'sd693598675;
	localparam q30_t SIN_C1 = 33'sd1686629713;

	// 2^-f = e^-(f*ln2), series in g = f*ln2
	localparam q30_t LN2_Q30 = 33'sd744261118;
	localparam q30_t EXP_C7  = -33'sd213044;
	localparam q30_t EXP_C6  = 33'sd1491308;
	localparam q30_t EXP_C5  = -33'sd8947849;
	localparam q30_t EXP_C4  = 33'sd44739243;
	localparam q30_t EXP_C3  = -33'sd178956971;
	localparam q30_t EXP_C2  = 33'sd536870912;
	localparam q30_t EXP_C1  = -33'sd1073741824;
	localparam q30_t EXP_C0  = 33'sd1073741824;

	// phase offsets of the elastic curves, Q30
	localparam logic signed [36:0] OFS_ELASTIC_IN  = 37'sd11542724608;
	localparam logic signed [36:0] OFS_ELASTIC_OUT = 37'sd805306368;
	localparam logic signed [36:0] OFS_ELASTIC_IO  = 37'sd23890755584;
	localparam logic signed [36:0] TEN_ONE         = 37'sd10737418240;

	// m = mh*2^18 + ml; 2^18 = 1 mod 3 and mod 9, so
	// m/d = mh*(2^18-1)/d + (mh+ml)/d, the tail by reciprocal (exact below 2^21)
	localparam logic [16:0] DIV3_HI  = 17'd87381;
	localparam logic [16:0] DIV9_HI  = 17'd29127;
	localparam logic [19:0] DIV3_RCP = 20'd699051;
	localparam logic [19:0] DIV9_RCP = 20'd233017;

	// Q30 product, truncated toward zero
	function automatic q30_t fmul(input q30_t a, input q30_t b);
		logic [32:0] ma;
		logic [32:0] mb;
		logic [65:0] p;
		q30_t        r;
		ma = a[32] ? 33'(-a) : 33'(a);
		mb = b[32] ? 33'(-b) : 33'(b);
		p  = ma * mb;
		r  = $signed(p[62:30]);
		return (a[32] ^ b[32]) ? -r : r;
	endfunction

	function automatic q30_t clamp01(input q30_t v);
		q30_t r;
		if (v < 0)
			r = '0;
		else if (v > ONE)
			r = ONE;
		else
			r = v;
		return r;
	endfunction

	// floor(m / 3) or floor(m / 9)
	function automatic logic [35:0] div_const(input logic [35:0] m, input logic by9);
		logic [18:0] s;
		logic [34:0] hi;
		logic [38:0] ps;
		s  = {1'b0, m[35:18]} + {1'b0, m[17:0]};
		hi = m[35:18] * (by9 ? DIV9_HI : DIV3_HI);
		ps = s * (by9 ? DIV9_RCP : DIV3_RCP);
		return 36'(hi) + 36'(ps[38:21]);
	endfunction

endpackage

FILE: hw/rtl/easing_curve_unit.sv
// easing_curve_unit: pipelined evaluator of eight easing curves.
// Depends on ecu_pkg (types, coefficients, fmul/clamp01/div_const).
//
// Usage:
//  - s_axis_*: one position per transaction, unsigned, 2^IN_FRAC_BITS = 1.0;
//    values above 1.0 are clamped to 1.0.
//  - m_axis_*: one eased value per input transaction, signed, 2^OUT_FRAC_BITS
//    = 1.0, rounded half away from zero and saturated to 16 bits.
//  - cfg_*: writes curve_mode; always ready. Write only while the pipeline
//    is empty, results in flight use the mode captured at input.
//  - Throughput is one transaction per cycle when there is no backpressure
//    from m_axis_tready. The depth is set by the 2^-t polynomial: argument
//    scaling plus seven dependent multiply-add stages, then the final
//    product, curve select and rounding.
//  - A stage holds at most one registered multiply per lane (sine, exp, power).
//  - Reset clears all valid bits and sets curve_mode to linear.
//  - When m_axis_tready is low the output register holds; earlier stages
//    keep filling bubbles, and s_axis_tready drops once every stage is full.
module easing_curve_unit #(
	parameter int IN_FRAC_BITS  = 15,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] curve_position
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] eased_value
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);

	localparam int NSTAGE    = 13;
	localparam int IN_SHIFT  = 30 - IN_FRAC_BITS;
	localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;
	localparam logic [31:0] ONE_IN     = 32'd1 << IN_FRAC_BITS;
	localparam logic [33:0] ROUND_BIAS = 34'd1 << (OUT_SHIFT - 1);
	localparam logic [15:0] ONE_OUT    = (OUT_FRAC_BITS >= 15) ? 16'h7FFF
	                                     : 16'(32'd1 << OUT_FRAC_BITS);

	logic [2:0] curve_mode_q;

	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] vld_in;
	logic [NSTAGE:1] en;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_mode_q <= ecu_pkg::MODE_LINEAR;
		end else if (cfg_valid) begin
			curve_mode_q <= cfg_data;
		end
	end

	// ---------------- flow control ----------------
	always_comb begin
		en[NSTAGE] = !vld_q[NSTAGE] || m_axis_tready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign vld_in        = {vld_q[NSTAGE-1:1], s_axis_tvalid};
	assign s_axis_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_in & en) | (vld_q & ~en);
		end
	end

	// ---------------- stage 1: input scaling ----------------
	logic [31:0]      raw_ext;
	logic [31:0]      raw_clamp;
	logic [31:0]      x_shift;
	ecu_pkg::q30_t    x_in;
	ecu_pkg::q30_t    x_s1;
	ecu_pkg::ctl_t    ctl_s1;

	assign raw_ext   = {16'd0, s_axis_tdata};
	assign raw_clamp = (raw_ext > ONE_IN) ? ONE_IN : raw_ext;
	assign x_shift   = raw_clamp << IN_SHIFT;
	assign x_in      = $signed({1'b0, x_shift});

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1         <= x_in;
			ctl_s1.mode  <= curve_mode_q;
			ctl_s1.zero  <= (x_in == '0);
			ctl_s1.one   <= (x_in == ecu_pkg::ONE);
			ctl_s1.lower <= (x_in < ecu_pkg::HALF);
		end
	end

	// ---------------- stage 2: phase numerator, exp argument, power base ----
	logic signed [36:0] x37;
	logic signed [36:0] x10;
	logic signed [36:0] x20;
	logic signed [36:0] x40;
	logic signed [36:0] num;
	logic signed [36:0] targ;
	ecu_pkg::q30_t      b_in;

	ecu_pkg::ctl_t  ctl_s2;
	ecu_pkg::q30_t  x_s2;
	logic [35:0]    mag_s2;
	logic           nneg_s2;
	logic [3:0]     n_s2;
	logic [29:0]    frac_s2;
	ecu_pkg::q30_t  b_s2;

	assign x37 = 37'(x_s1);
	assign x10 = (x37 <<< 3) + (x37 <<< 1);
	assign x20 = x10 <<< 1;
	assign x40 = x10 <<< 2;

	always_comb begin
		case (ctl_s1.mode)
			ecu_pkg::MODE_ELASTIC_IN: begin
				num  = x10 - ecu_pkg::OFS_ELASTIC_IN;
				targ = ecu_pkg::TEN_ONE - x10;
			end
			ecu_pkg::MODE_ELASTIC_OUT: begin
				num  = x10 - ecu_pkg::OFS_ELASTIC_OUT;
				targ = x10;
			end
			ecu_pkg::MODE_ELASTIC_IO: begin
				num  = x40 - ecu_pkg::OFS_ELASTIC_IO;
				targ = ctl_s1.lower ? (ecu_pkg::TEN_ONE - x20) : (x20 - ecu_pkg::TEN_ONE);
			end
			default: begin
				num  = '0;
				targ = '0;
			end
		endcase
	end

	always_comb begin
		case (ctl_s1.mode)
			ecu_pkg::MODE_QUART_OUT: b_in = ecu_pkg::ONE - x_s1;
			ecu_pkg::MODE_CUBIC_IO:  b_in = ctl_s1.lower ? x_s1 : ((ecu_pkg::ONE - x_s1) <<< 1);
			default:                 b_in = x_s1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ctl_s2  <= ctl_s1;
			x_s2    <= x_s1;
			mag_s2  <= num[36] ? 36'(-num) : 36'(num);
			nneg_s2 <= num[36];
			n_s2    <= targ[36] ? 4'd0 : targ[33:30];
			frac_s2 <= targ[36] ? 30'd0 : targ[29:0];
			b_s2    <= b_in;
		end
	end

	// ---------------- stage 3: phase in turns, exp scaling, first power ----
	logic [35:0] quot;
	logic [35:0] quot_sgn;

	ecu_pkg::ctl_t  ctl_s3;
	logic [29:0]    turns_s3;
	ecu_pkg::q30_t  g_s3;
	logic [3:0]     n_s3;
	ecu_pkg::q30_t  p1_s3;
	ecu_pkg::q30_t  b_s3;

	assign quot     = ecu_pkg::div_const(mag_s2, ctl_s2.mode == ecu_pkg::MODE_ELASTIC_IO);
	assign quot_sgn = nneg_s2 ? (~quot + 36'd1) : quot;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ctl_s3   <= ctl_s2;
			turns_s3 <= (ctl_s2.mode == ecu_pkg::MODE_SINE_OUT) ? {1'b0, x_s2[30:2]}
			            : quot_sgn[29:0];
			g_s3     <= ecu_pkg::fmul($signed({3'b000, frac_s2}), ecu_pkg::LN2_Q30);
			n_s3     <= n_s2;
			p1_s3    <= ecu_pkg::fmul(b_s2, b_s2);
			b_s3     <= b_s2;
		end
	end

	// ---------------- stage 4: quadrant fold ----------------
	ecu_pkg::q30_t u_raw;
	ecu_pkg::q30_t u_fold;

	ecu_pkg::ctl_t  ctl_s4;
	ecu_pkg::q30_t  u_s4;
	ecu_pkg::q30_t  u2_s4;
	logic [1:0]     quad_s4;
	ecu_pkg::q30_t  r_s4;
	ecu_pkg::q30_t  g_s4;
	logic [3:0]     n_s4;
	ecu_pkg::q30_t  p_s4;

	assign u_raw  = $signed({3'b000, turns_s3[27:0], 2'b00});
	assign u_fold = turns_s3[28] ? (ecu_pkg::ONE - u_raw) : u_raw;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ctl_s4  <= ctl_s3;
			u_s4    <= u_fold;
			u2_s4   <= ecu_pkg::fmul(u_fold, u_fold);
			quad_s4 <= turns_s3[29:28];
			r_s4    <= ecu_pkg::EXP_C6 + ecu_pkg::fmul(ecu_pkg::EXP_C7, g_s3);
			g_s4    <= g_s3;
			n_s4    <= n_s3;
			case (ctl_s3.mode)
				ecu_pkg::MODE_LINEAR:    p_s4 <= b_s3;
				ecu_pkg::MODE_QUART_OUT: p_s4 <= ecu_pkg::fmul(p1_s3, p1_s3);
				default:                 p_s4 <= ecu_pkg::fmul(p1_s3, b_s3);
			endcase
		end
	end

	// ---------------- stages 5..8: Horner steps ----------------
	ecu_pkg::ctl_t  ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	ecu_pkg::q30_t  u_s5, u_s6, u_s7, u_s8;
	ecu_pkg::q30_t  u2_s5, u2_s6, u2_s7;
	logic [1:0]     quad_s5, quad_s6, quad_s7, quad_s8;
	ecu_pkg::q30_t  t_s5, t_s6, t_s7, t_s8;
	ecu_pkg::q30_t  r_s5, r_s6, r_s7, r_s8;
	ecu_pkg::q30_t  g_s5, g_s6, g_s7, g_s8;
	logic [3:0]     n_s5, n_s6, n_s7, n_s8;
	ecu_pkg::q30_t  p_s5, p_s6, p_s7, p_s8;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ctl_s5  <= ctl_s4;
			u_s5    <= u_s4;
			u2_s5   <= u2_s4;
			quad_s5 <= quad_s4;
			t_s5    <= ecu_pkg::SIN_C7 + ecu_pkg::fmul(ecu_pkg::SIN_C9, u2_s4);
			r_s5    <= ecu_pkg::EXP_C5 + ecu_pkg::fmul(r_s4, g_s4);
			g_s5    <= g_s4;
			n_s5    <= n_s4;
			p_s5    <= p_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			ctl_s6  <= ctl_s5;
			u_s6    <= u_s5;
			u2_s6   <= u2_s5;
			quad_s6 <= quad_s5;
			t_s6    <= ecu_pkg::SIN_C5 + ecu_pkg::fmul(t_s5, u2_s5);
			r_s6    <= ecu_pkg::EXP_C4 + ecu_pkg::fmul(r_s5, g_s5);
			g_s6    <= g_s5;
			n_s6    <= n_s5;
			p_s6    <= p_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			ctl_s7  <= ctl_s6;
			u_s7    <= u_s6;
			u2_s7   <= u2_s6;
			quad_s7 <= quad_s6;
			t_s7    <= ecu_pkg::SIN_C3 + ecu_pkg::fmul(t_s6, u2_s6);
			r_s7    <= ecu_pkg::EXP_C3 + ecu_pkg::fmul(r_s6, g_s6);
			g_s7    <= g_s6;
			n_s7    <= n_s6;
			p_s7    <= p_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			ctl_s8  <= ctl_s7;
			u_s8    <= u_s7;
			quad_s8 <= quad_s7;
			t_s8    <= ecu_pkg::SIN_C1 + ecu_pkg::fmul(t_s7, u2_s7);
			r_s8    <= ecu_pkg::EXP_C2 + ecu_pkg::fmul(r_s7, g_s7);
			g_s8    <= g_s7;
			n_s8    <= n_s7;
			p_s8    <= p_s7;
		end
	end

	// ---------------- stage 9: sine result ----------------
	ecu_pkg::q30_t sin_mag;

	ecu_pkg::ctl_t  ctl_s9;
	ecu_pkg::q30_t  sin_s9;
	ecu_pkg::q30_t  r_s9;
	ecu_pkg::q30_t  g_s9;
	logic [3:0]     n_s9;
	ecu_pkg::q30_t  p_s9;

	assign sin_mag = ecu_pkg::clamp01(ecu_pkg::fmul(t_s8, u_s8));

	always_ff @(posedge clk) begin
		if (en[9]) begin
			ctl_s9 <= ctl_s8;
			sin_s9 <= quad_s8[1] ? -sin_mag : sin_mag;
			r_s9   <= ecu_pkg::EXP_C1 + ecu_pkg::fmul(r_s8, g_s8);
			g_s9   <= g_s8;
			n_s9   <= n_s8;
			p_s9   <= p_s8;
		end
	end

	// ---------------- stage 10: 2^-t result ----------------
	ecu_pkg::q30_t exp_frac;

	ecu_pkg::ctl_t  ctl_s10;
	ecu_pkg::q30_t  a_s10;
	ecu_pkg::q30_t  sin_s10;
	ecu_pkg::q30_t  p_s10;

	assign exp_frac = ecu_pkg::clamp01(ecu_pkg::EXP_C0 + ecu_pkg::fmul(r_s9, g_s9));

	always_ff @(posedge clk) begin
		if (en[10]) begin
			ctl_s10 <= ctl_s9;
			a_s10   <= exp_frac >>> n_s9;
			sin_s10 <= sin_s9;
			p_s10   <= p_s9;
		end
	end

	// ---------------- stage 11: envelope times sine ----------------
	ecu_pkg::ctl_t  ctl_s11;
	ecu_pkg::q30_t  prod_s11;
	ecu_pkg::q30_t  sin_s11;
	ecu_pkg::q30_t  p_s11;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			ctl_s11  <= ctl_s10;
			prod_s11 <= ecu_pkg::fmul(a_s10, sin_s10);
			sin_s11  <= sin_s10;
			p_s11    <= p_s10;
		end
	end

	// ---------------- stage 12: curve select ----------------
	ecu_pkg::q30_t prod_half;
	ecu_pkg::q30_t y_sel;

	ecu_pkg::ctl_t  ctl_s12;
	ecu_pkg::q30_t  y_s12;

	// halve toward zero
	assign prod_half = (prod_s11 + $signed({32'd0, prod_s11[32]})) >>> 1;

	always_comb begin
		case (ctl_s11.mode)
			ecu_pkg::MODE_LINEAR:   y_sel = p_s11;
			ecu_pkg::MODE_CUBIC_IN: y_sel = p_s11;
			ecu_pkg::MODE_ELASTIC_IN: begin
				if (ctl_s11.zero)
					y_sel = '0;
				else if (ctl_s11.one)
					y_sel = ecu_pkg::ONE;
				else
					y_sel = -prod_s11;
			end
			ecu_pkg::MODE_SINE_OUT: y_sel = sin_s11;
			ecu_pkg::MODE_ELASTIC_OUT: begin
				if (ctl_s11.zero)
					y_sel = '0;
				else if (ctl_s11.one)
					y_sel = ecu_pkg::ONE;
				else
					y_sel = prod_s11 + ecu_pkg::ONE;
			end
			ecu_pkg::MODE_CUBIC_IO: begin
				y_sel = ctl_s11.lower ? (p_s11 <<< 2) : (ecu_pkg::ONE - (p_s11 >>> 1));
			end
			ecu_pkg::MODE_ELASTIC_IO: begin
				if (ctl_s11.zero)
					y_sel = '0;
				else if (ctl_s11.one)
					y_sel = ecu_pkg::ONE;
				else if (ctl_s11.lower)
					y_sel = -prod_half;
				else
					y_sel = prod_half + ecu_pkg::ONE;
			end
			default: y_sel = ecu_pkg::ONE - p_s11;  // quartic out
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[12]) begin
			ctl_s12 <= ctl_s11;
			y_s12   <= y_sel;
		end
	end

	// ---------------- stage 13: round and saturate ----------------
	logic        y_neg;
	logic [32:0] y_mag;
	logic [33:0] y_rnd;
	logic [33:0] y_rnd_neg;
	logic [15:0] y_out;
	logic [15:0] eased_s13;

	assign y_neg     = y_s12[32];
	assign y_mag     = y_neg ? 33'(-y_s12) : 33'(y_s12);
	assign y_rnd     = ({1'b0, y_mag} + ROUND_BIAS) >> OUT_SHIFT;
	assign y_rnd_neg = ~y_rnd + 34'd1;

	always_comb begin
		if (y_neg)
			y_out = (y_rnd > 34'd32768) ? 16'h8000 : y_rnd_neg[15:0];
		else
			y_out = (y_rnd > 34'd32767) ? 16'h7FFF : y_rnd[15:0];
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			eased_s13 <= y_out;
		end
	end

	assign m_axis_tvalid = vld_q[NSTAGE];
	assign m_axis_tdata  = eased_s13;

	// ---------------- assertions ----------------
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	a_elastic_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[12] && en[13] && ctl_s12.zero &&
		 (ctl_s12.mode == ecu_pkg::MODE_ELASTIC_IN ||
		  ctl_s12.mode == ecu_pkg::MODE_ELASTIC_OUT ||
		  ctl_s12.mode == ecu_pkg::MODE_ELASTIC_IO))
		|=> (m_axis_tdata == 16'd0))
		else $error("elastic curve at position 0 not zero");

	a_elastic_one: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[12] && en[13] && ctl_s12.one &&
		 (ctl_s12.mode == ecu_pkg::MODE_ELASTIC_IN ||
		  ctl_s12.mode == ecu_pkg::MODE_ELASTIC_OUT ||
		  ctl_s12.mode == ecu_pkg::MODE_ELASTIC_IO))
		|=> (m_axis_tdata == ONE_OUT))
		else $error("elastic curve at position 1.0 not one");

endmodule

FILE: sim/easing_curve_unit_tb.sv
`timescale 1ns / 1ps
// easing_curve_unit_tb: self-checking bench for easing_curve_unit, all eight curves.
// Depends on ecu_pkg (curve codes) and easing_curve_unit; has its own Q30 predictor.
module easing_curve_unit_tb;

	localparam longint Q_ONE   = 64'sd1073741824;
	localparam longint Q_FMASK = 64'sd1073741823;
	localparam int     LIMIT   = 400000;
	localparam int     DRAIN   = 24;   // larger than the pipeline depth

	typedef struct {
		logic [2:0]  mode;
		logic [15:0] pos;
		bit          fixed;   // expected value typed in below
		logic [15:0] val;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_data = '0;

	logic [15:0] pending_eased[$];
	logic [2:0]  active_mode;
	int          fail_count = 0;
	int          cycle_count = 0;
	int          burst_left = 0;

	easing_curve_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// ---------------- predictor, Q30 in 64-bit integers ----------------
	function automatic longint qmul(input longint a, input longint b);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [127:0] p;
		longint       r;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p  = {64'd0, ma} * {64'd0, mb};
		r  = longint'(p[93:30]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint sat01(input longint v);
		if (v < 0)
			return 0;
		if (v > Q_ONE)
			return Q_ONE;
		return v;
	endfunction

	function automatic longint quarter_wave(input longint u);
		longint u2;
		longint t;
		u2 = qmul(u, u);
		t  = 172272;
		t  = -5026993 + qmul(t, u2);
		t  = 85569306 + qmul(t, u2);
		t  = -693598675 + qmul(t, u2);
		t  = 1686629713 + qmul(t, u2);
		return sat01(qmul(t, u));
	endfunction

	function automatic longint sine_of_turns(input longint turns);
		longint p;
		longint q;
		longint u;
		longint s;
		p = turns & Q_FMASK;
		q = p >>> 28;
		u = (p & (Q_FMASK >>> 2)) << 2;
		s = q[0] ? quarter_wave(Q_ONE - u) : quarter_wave(u);
		return q[1] ? -s : s;
	endfunction

	function automatic longint pow2_neg(input longint t);
		longint n;
		longint g;
		longint r;
		if (t < 0)
			t = 0;
		n = t >>> 30;
		g = qmul(t & Q_FMASK, 744261118);
		r = -213044;
		r = 1491308 + qmul(r, g);
		r = -8947849 + qmul(r, g);
		r = 44739243 + qmul(r, g);
		r = -178956971 + qmul(r, g);
		r = 536870912 + qmul(r, g);
		r = -Q_ONE + qmul(r, g);
		r = Q_ONE + qmul(r, g);
		r = sat01(r);
		if (n >= 31)
			return 0;
		return r >>> n;
	endfunction

	function automatic longint ease_q30(input logic [2:0] mode, input longint x);
		longint a;
		longint b;
		longint q28;
		q28 = 64'sd268435456;
		case (mode)
			ecu_pkg::MODE_LINEAR: return x;
			ecu_pkg::MODE_CUBIC_IN: return qmul(qmul(x, x), x);
			ecu_pkg::MODE_ELASTIC_IN: begin
				if (x == 0)
					return 0;
				if (x == Q_ONE)
					return Q_ONE;
				a = pow2_neg(10 * Q_ONE - 10 * x);
				b = sine_of_turns((10 * x - 43 * q28) / 3);
				return -qmul(a, b);
			end
			ecu_pkg::MODE_SINE_OUT: return sine_of_turns(x / 4);
			ecu_pkg::MODE_ELASTIC_OUT: begin
				if (x == 0)
					return 0;
				if (x == Q_ONE)
					return Q_ONE;
				a = pow2_neg(10 * x);
				b = sine_of_turns((10 * x - 3 * q28) / 3);
				return qmul(a, b) + Q_ONE;
			end
			ecu_pkg::MODE_CUBIC_IO: begin
				if (x < Q_ONE / 2)
					return 4 * qmul(qmul(x, x), x);
				a = 2 * Q_ONE - 2 * x;
				return Q_ONE - qmul(qmul(a, a), a) / 2;
			end
			ecu_pkg::MODE_ELASTIC_IO: begin
				if (x == 0)
					return 0;
				if (x == Q_ONE)
					return Q_ONE;
				b = sine_of_turns((40 * x - 89 * q28) / 9);
				if (x < Q_ONE / 2) begin
					a = pow2_neg(10 * Q_ONE - 20 * x);
					return -(qmul(a, b) / 2);
				end
				a = pow2_neg(20 * x - 10 * Q_ONE);
				return qmul(a, b) / 2 + Q_ONE;
			end
			default: begin
				a = Q_ONE - x;
				a = qmul(a, a);
				return Q_ONE - qmul(a, a);
			end
		endcase
	endfunction

	// position word to eased output word: clamp, Q30, round half away, saturate
	function automatic logic [15:0] eased_word(input logic [2:0] mode,
			input logic [15:0] pos);
		longint raw;
		longint y;
		longint m;
		raw = pos;
		if (raw > 32768)
			raw = 32768;
		y = ease_q30(mode, raw << 15);
		m = (y < 0) ? -y : y;
		m = (m + 32768) >>> 16;
		if (y < 0)
			return (m > 32768) ? 16'h8000 : 16'(-m);
		return (m > 32767) ? 16'h7fff : 16'(m);
	endfunction

	// ---------------- stimulus ----------------
	task automatic wait_empty();
		while (pending_eased.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_mode(input logic [2:0] mode);
		wait_empty();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		active_mode  = mode;
	endtask

	task automatic push_position(input logic [15:0] pos, input bit fixed,
			input logic [15:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pos;
		do @(posedge clk); while (!s_axis_tready);
		pending_eased.push_back(fixed ? val : eased_word(active_mode, pos));
		burst_left--;
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
	endtask

	dir_row_t dir_rows[25] = '{
		'{ecu_pkg::MODE_LINEAR,      16'd0,     1'b1, 16'd0},
		'{ecu_pkg::MODE_LINEAR,      16'd32768, 1'b1, 16'd16384},
		'{ecu_pkg::MODE_LINEAR,      16'd65535, 1'b1, 16'd16384},   // above 1.0 clamps
		'{ecu_pkg::MODE_LINEAR,      16'd16384, 1'b1, 16'd8192},
		'{ecu_pkg::MODE_LINEAR,      16'd1,     1'b0, 16'd0},
		'{ecu_pkg::MODE_CUBIC_IN,    16'd0,     1'b1, 16'd0},
		'{ecu_pkg::MODE_CUBIC_IN,    16'd32768, 1'b1, 16'd16384},
		'{ecu_pkg::MODE_ELASTIC_IN,  16'd0,     1'b1, 16'd0},
		'{ecu_pkg::MODE_ELASTIC_IN,  16'd32768, 1'b1, 16'd16384},
		'{ecu_pkg::MODE_ELASTIC_IN,  16'd40000, 1'b1, 16'd16384},
		'{ecu_pkg::MODE_ELASTIC_IN,  16'd32767, 1'b0, 16'd0},
		'{ecu_pkg::MODE_SINE_OUT,    16'd0,     1'b1, 16'd0},
		'{ecu_pkg::MODE_SINE_OUT,    16'd32768, 1'b0, 16'd0},
		'{ecu_pkg::MODE_ELASTIC_OUT, 16'd0,     1'b1, 16'd0},
		'{ecu_pkg::MODE_ELASTIC_OUT, 16'd32768, 1'b1, 16'd16384},
		'{ecu_pkg::MODE_ELASTIC_OUT, 16'd1,     1'b0, 16'd0},
		'{ecu_pkg::MODE_CUBIC_IO,    16'd16383, 1'b0, 16'd0},       // just below the split
		'{ecu_pkg::MODE_CUBIC_IO,    16'd16384, 1'b0, 16'd0},
		'{ecu_pkg::MODE_ELASTIC_IO,  16'd0,     1'b1, 16'd0},
		'{ecu_pkg::MODE_ELASTIC_IO,  16'd32768, 1'b1, 16'd16384},
		'{ecu_pkg::MODE_ELASTIC_IO,  16'd16383, 1'b0, 16'd0},
		'{ecu_pkg::MODE_ELASTIC_IO,  16'd16384, 1'b0, 16'd0},
		'{ecu_pkg::MODE_QUART_OUT,   16'd0,     1'b1, 16'd0},
		'{ecu_pkg::MODE_QUART_OUT,   16'd32768, 1'b1, 16'd16384},
		'{ecu_pkg::MODE_QUART_OUT,   16'd65535, 1'b1, 16'd16384}
	};

	initial begin
		logic [2:0]  mode;
		logic [15:0] pos;
		active_mode = ecu_pkg::MODE_LINEAR;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != active_mode) begin
				stop_sending();
				write_mode(dir_rows[i].mode);
			end
			push_position(dir_rows[i].pos, dir_rows[i].fixed, dir_rows[i].val);
		end
		for (int ph = 0; ph < 12; ph++) begin
			// visit every curve, then extremes and random picks
			mode = (ph < 8) ? 3'(ph) : (ph == 8) ? ecu_pkg::MODE_LINEAR :
				(ph == 9) ? ecu_pkg::MODE_QUART_OUT : 3'($urandom_range(0, 7));
			stop_sending();
			write_mode(mode);
			for (int k = 0; k < 58; k++) begin
				case ($urandom_range(0, 9))
					0: pos = 16'($urandom_range(0, 65535));          // all bits, above 1.0
					1: pos = 16'($urandom_range(16376, 16392));      // around the split
					2: pos = 16'($urandom_range(0, 8));
					3: pos = 16'($urandom_range(32760, 32768));
					default: pos = 16'($urandom_range(0, 32768));
				endcase
				push_position(pos, 1'b0, 16'd0);
			end
		end
		stop_sending();
		wait_empty();
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- result check and receiver stalls ----------------
	int stall_style = 0;

	always @(posedge clk) begin
		logic [15:0] want;
		cycle_count <= cycle_count + 1;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_eased.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual %0d",
					$time, $signed(m_axis_tdata));
				fail_count++;
			end else begin
				want = pending_eased.pop_front();
				if (m_axis_tdata !== want) begin
					$display("%0t: eased_value mismatch, expected %0d, actual %0d",
						$time, $signed(want), $signed(m_axis_tdata));
					fail_count++;
				end
			end
		end
		if (cycle_count % 97 == 0)
			stall_style = $urandom_range(0, 3);
		case (stall_style)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= ($urandom_range(0, 1) == 1);
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default: m_axis_tready <= (cycle_count % 8 < 5);
		endcase
	end

	always @(posedge clk) begin
		if (cycle_count > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

FILE: files.f
hw/rtl/ecu_pkg.sv
hw/rtl/easing_curve_unit.sv
sim/easing_curve_unit_tb.sv
